FILE: hdl/swrl_pkg.sv
// Shared types and constants for the sliding window rate limiter.
`default_nettype none

package swrl_pkg;

  // Default geometry
  localparam int unsigned RingDepthDef = 64;
  localparam int unsigned TimeBitsDef  = 48;

  // Field widths
  localparam int unsigned TimeInW = 48;
  localparam int unsigned WindowW = 40;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = WindowW;

  // Register reset values
  localparam logic [WindowW-1:0] WindowReset    = WindowW'(1000000);
  localparam logic [CountW-1:0]  MaxEventsReset = CountW'(10);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgWindow    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxEvents = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStrict    = 2'd2;

  // Request kinds
  localparam logic ReqAdmit = 1'b0;
  localparam logic ReqClear = 1'b1;

  // Input word
  typedef struct packed {
    logic               req_type;
    logic [TimeInW-1:0] time_us;
  } swrl_req_t;

  // Result word
  typedef struct packed {
    logic              accepted;
    logic [CountW-1:0] expired_count;
    logic [CountW-1:0] occupancy;
  } swrl_res_t;

endpackage

`default_nettype wire

FILE: hdl/sliding_window_rate_limiter.sv
// Top level: sliding log rate limiter with the stamp ring in a synchronous memory.
//
//  channel   signals                            direction  transfer
//  request   start, busy, req_i                 in         start && !busy
//  result    done_o, res_o                      out        done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i   in         cfg_we_i
//
// An admission word first reads the oldest stamp from the ring memory,
// then runs the read-compare loop on the ring memory, expiring one stamp
// per pass, and ends in the decision.
// A clear word is handled in the idle state and leaves busy low.
// The result shows on the cycle after the decision; the receiver cannot stall.
// Reset clears pointer, count, state and the configuration registers; the ring needs no clearing pass.
`default_nettype none

module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef,
  parameter int unsigned TIME_BITS  = TimeBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire swrl_req_t           req_i,
  output logic                     done_o,
  output swrl_res_t                res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(RING_DEPTH);

  // Sequencer codes
  localparam logic SIdle  = 1'b0;
  localparam logic SCheck = 1'b1;

  // Configuration registers
  logic [WindowW-1:0] window_q;
  logic [CountW-1:0]  max_events_q;
  logic               strict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= WindowReset;
      max_events_q <= MaxEventsReset;
      strict_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow:    window_q     <= cfg_wdata_i[WindowW-1:0];
        CfgMaxEvents: max_events_q <= cfg_wdata_i[CountW-1:0];
        CfgStrict:    strict_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  logic            state_q, state_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] exp_q, exp_d;
  logic            done_q, done_d;
  swrl_res_t       res_q, res_d;

  // Request time, held for the loop
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS+TimeInW-1:0] time_ext;
  assign time_ext = {{TIME_BITS{1'b0}}, req_i.time_us};

  // Ring memory
  logic [TIME_BITS-1:0] ring_mem [RING_DEPTH];
  logic [TIME_BITS-1:0] rd_data_q;
  logic                 wr_en;
  logic [PtrW-1:0]      wr_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= now_q;
    end
    rd_data_q <= ring_mem[ptr_d];
  end

  // Age compare against the oldest stamp
  logic [TIME_BITS-1:0]         diff;
  logic [TIME_BITS+WindowW-1:0] diff_x, win_x;
  logic                         now_gt, now_ge, too_old, strict_ok;

  assign diff      = now_q - rd_data_q;
  assign diff_x    = {{WindowW{1'b0}}, diff};
  assign win_x     = {{TIME_BITS{1'b0}}, window_q};
  assign now_gt    = now_q > rd_data_q;
  assign now_ge    = now_q >= rd_data_q;
  assign too_old   = (cnt_q != '0) && now_gt && (diff_x > win_x);
  assign strict_ok = now_ge && (diff_x >= win_x);

  // Young end slot: ptr + count modulo depth
  logic [CntW:0] slot_sum;
  logic [CntW:0] slot_mod;
  assign slot_sum = {{(CntW + 1 - PtrW){1'b0}}, ptr_q} + {1'b0, cnt_q};
  assign slot_mod = (slot_sum >= (CntW + 1)'(RING_DEPTH)) ?
                    slot_sum - (CntW + 1)'(RING_DEPTH) : slot_sum;
  assign wr_addr  = slot_mod[PtrW-1:0];

  // Count limit compare and 7-bit views
  logic [CntW+CountW-1:0] cnt_x, max_x, cnt_new_x, exp_x;
  logic                   admit;
  logic [CntW-1:0]        cnt_new;

  assign cnt_x = {{CountW{1'b0}}, cnt_q};
  assign max_x = {{CntW{1'b0}}, max_events_q};

  always_comb begin
    if (cnt_q == '0) begin
      admit = 1'b1;
    end else if (cnt_q == CntFull) begin
      admit = 1'b0;
    end else if (strict_q) begin
      admit = strict_ok;
    end else begin
      admit = cnt_x < max_x;
    end
  end

  assign cnt_new   = admit ? cnt_q + 1'b1 : cnt_q;
  assign cnt_new_x = {{CountW{1'b0}}, cnt_new};
  assign exp_x     = {{CountW{1'b0}}, exp_q};

  // Sequencer
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    now_d   = now_q;
    done_d  = 1'b0;
    res_d   = res_q;
    wr_en   = 1'b0;
    case (state_q)
      SIdle: begin
        if (start) begin
          if (req_i.req_type == ReqClear) begin
            ptr_d  = '0;
            cnt_d  = '0;
            done_d = 1'b1;
            res_d  = '0;
          end else begin
            now_d   = time_ext[TIME_BITS-1:0];
            exp_d   = '0;
            state_d = SCheck;
          end
        end
      end
      SCheck: begin
        if (too_old) begin
          // drop oldest, prefetch the next one
          ptr_d = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
          cnt_d = cnt_q - 1'b1;
          exp_d = exp_q + 1'b1;
        end else begin
          wr_en   = admit;
          cnt_d   = cnt_new;
          done_d  = 1'b1;
          res_d.accepted      = admit;
          res_d.expired_count = exp_x[CountW-1:0];
          res_d.occupancy     = cnt_new_x[CountW-1:0];
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ptr_q   <= '0;
      cnt_q   <= '0;
      exp_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    res_q <= res_d;
  end

  assign busy   = (state_q == SCheck);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

FILE: hdl/swrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
`default_nettype none

module swrl_checker
  import swrl_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire swrl_req_t req_i,
  input wire logic      done_o,
  input wire swrl_res_t res_o
);

  // A clear word answers next cycle with an empty, refused result
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == ReqClear
      |=> done_o && !res_o.accepted && res_o.occupancy == '0 &&
          res_o.expired_count == '0)
    else $error("clear word did not give an empty result");

  // An admission word always enters the compare loop
  a_admit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.req_type == ReqAdmit |=> busy && !done_o)
    else $error("admission word did not raise busy");

  // The loop ends exactly with a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result never shows while the loop still runs
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire
